/* rtl/aatc_pkg.sv */
// Package for the arm angle thrust controller: constants, payload types and the sine table.
package aatc_pkg;

  localparam int SINE_TABLE_DEPTH = 256;  // power of two
  localparam int ANGLE_FRAC_BITS  = 12;

  localparam int SinIdxW  = $clog2(SINE_TABLE_DEPTH);
  localparam int SinShift = ANGLE_FRAC_BITS + 30 - SinIdxW;

  localparam logic [63:0] HalfPiQ30    = 64'd1686629713;
  localparam logic [31:0] TwoOverPiQ30 = 32'd683565276;

  localparam logic [1:0] OpPid     = 2'd0;
  localparam logic [1:0] OpCascade = 2'd1;
  localparam logic [1:0] OpLead    = 2'd2;

  localparam logic [2:0] RegFfGain    = 3'd0;
  localparam logic [2:0] RegLeadB0    = 3'd1;
  localparam logic [2:0] RegLeadB1    = 3'd2;
  localparam logic [2:0] RegLeadA1    = 3'd3;
  localparam logic [2:0] RegAngleGain = 3'd4;
  localparam logic [2:0] RegRateGain  = 3'd5;
  localparam logic [2:0] RegMaxThrust = 3'd6;

  typedef struct packed {
    logic [1:0]          op;
    logic signed [15:0]  target_angle;
    logic signed [15:0]  measured_angle;
    logic signed [15:0]  measured_rate;
  } in_item_t;

  typedef struct packed {
    logic [15:0] thrust;
    logic        invalid;
  } out_item_t;

  typedef logic [16:0] sin_tab_t [0:SINE_TABLE_DEPTH];

  // Quarter-wave sine table, Q16, built by a truncated Taylor series.
  function automatic sin_tab_t build_sin_tab();
    sin_tab_t           tab;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        e;
    logic [63:0]        t;
    logic signed [63:0] sum;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x    = (64'(k) * HalfPiQ30 + 64'(SINE_TABLE_DEPTH / 2)) >> SinIdxW;
      x2   = (x * x + (64'd1 << 29)) >> 30;
      term = x;
      sum  = signed'(x);
      for (int n = 1; n <= 7; n++) begin
        t = (term * x2) >> 30;
        // divide by (2n)(2n+1)
        case (n)
          1:       term = t / 64'd6;
          2:       term = t / 64'd20;
          3:       term = t / 64'd42;
          4:       term = t / 64'd72;
          5:       term = t / 64'd110;
          6:       term = t / 64'd156;
          default: term = t / 64'd210;
        endcase
        if ((n & 1) == 1) begin
          sum = sum - signed'(term);
        end else begin
          sum = sum + signed'(term);
        end
      end
      if (sum < 0) begin
        sum = 64'sd0;
      end
      e = (64'(sum) + (64'd1 << 13)) >> 14;
      if (e > 64'd65536) begin
        e = 64'd65536;
      end
      tab[k] = 17'(e);
    end
    return tab;
  endfunction

  localparam sin_tab_t SinTab = build_sin_tab();

endpackage

/* rtl/aatc_mul.sv */
// Bit-serial signed multiplier: 64-bit multiplicand, 32-bit multiplier, one bit per cycle.
module aatc_mul import aatc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               go_i,
  input  logic signed [63:0] a_i,
  input  logic signed [31:0] b_i,
  output logic               done_o,
  output logic signed [63:0] prod_o
);

  logic               busy_q;
  logic [4:0]         cnt_q;
  logic signed [63:0] a_q;
  logic [31:0]        b_q;
  logic signed [63:0] acc_q;
  logic               done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      a_q    <= '0;
      b_q    <= '0;
      acc_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && !go_i && (cnt_q == 5'd31);
      if (go_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        a_q    <= a_i;
        b_q    <= b_i;
        acc_q  <= '0;
      end else if (busy_q) begin
        // top multiplier bit carries negative weight
        if (b_q[0]) begin
          acc_q <= (cnt_q == 5'd31) ? acc_q - a_q : acc_q + a_q;
        end
        a_q   <= a_q <<< 1;
        b_q   <= b_q >> 1;
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

/* rtl/arm_angle_thrust_controller.sv */
// Top level: lead compensator / cascade controller with gravity feedforward.
//
//   channel | handshake               | payload
//   --------+-------------------------+-----------------------------
//   input   | in_valid_i / in_stall_o | in_data_i  (in_item_t)
//   output  | out_valid_o/out_stall_i | out_data_o (out_item_t)
//   config  | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// Each product runs through one shared bit-serial multiplier. A pid transaction
// goes from idle straight to done; cascade runs sin, ff, cas_err and cas_rate,
// and lead runs sin, ff, lead_b0, lead_b1 and lead_a1, one product each, before
// done, where the result may wait on a full, stalled output register.
// The next sample is taken once the current one is in the output register,
// even while that result is still stalled.
// Reset clears config registers (thrust cap to all ones) and both lead states.
module arm_angle_thrust_controller import aatc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SIN, ST_FF, ST_CAS_ERR, ST_CAS_RATE,
    ST_LEAD_B0, ST_LEAD_B1, ST_LEAD_A1, ST_DONE
  } state_e;

  // configuration
  logic signed [31:0] ff_gain_q, lead_b0_q, lead_b1_q, lead_a1_q;
  logic signed [31:0] angle_gain_q, rate_gain_q;
  logic [15:0]        thrust_cap_q;

  state_e             state_q;
  in_item_t           item_q;
  logic signed [15:0] err_q;
  logic signed [47:0] total_q;
  logic signed [63:0] acc_q;
  logic               inv_q;
  logic signed [15:0] prev_err_q;
  logic signed [31:0] prev_y_q;
  logic               out_valid_q;
  out_item_t          out_q;

  logic               mul_go_q;
  logic               mul_go_d;
  logic signed [63:0] mul_a_q;
  logic signed [31:0] mul_b_q;
  logic               mul_done;
  logic signed [63:0] mul_p;

  aatc_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (mul_go_q),
    .a_i    (mul_a_q),
    .b_i    (mul_b_q),
    .done_o (mul_done),
    .prod_o (mul_p)
  );

  // error and angle magnitude of the incoming sample
  logic signed [16:0] err_raw;
  logic signed [15:0] err_in;
  logic [16:0]        mag_in;
  logic               op_ok;

  always_comb begin
    err_raw = 17'(in_data_i.target_angle) - 17'(in_data_i.measured_angle);
    if (err_raw > 17'sd32767) begin
      err_in = 16'sh7fff;
    end else if (err_raw < -17'sd32768) begin
      err_in = 16'sh8000;
    end else begin
      err_in = err_raw[15:0];
    end
    mag_in = in_data_i.measured_angle[15] ? 17'd0 - {1'b1, in_data_i.measured_angle}
                                          : {1'b0, in_data_i.measured_angle};
    op_ok  = (in_data_i.op == OpCascade) || (in_data_i.op == OpLead);
  end

  // start a multiply on acceptance of a valid mode and after every product
  // that feeds another one
  always_comb begin
    mul_go_d = 1'b0;
    if (state_q == ST_IDLE) begin
      mul_go_d = in_valid_i && op_ok;
    end else if (mul_done) begin
      mul_go_d = state_q inside {ST_SIN, ST_FF, ST_CAS_ERR, ST_LEAD_B0, ST_LEAD_B1};
    end
  end

  // sine lookup from the index product: round, wrap to one turn, fold quadrant
  logic [63:0]          q_round;
  logic [SinIdxW+1:0]   qq;
  logic [SinIdxW:0]     sin_idx;
  logic [16:0]          sin_mag;
  logic signed [17:0]   sine_w;

  always_comb begin
    q_round = 64'(mul_p) + (64'd1 << (SinShift - 1));
    qq      = q_round[SinShift +: SinIdxW + 2];
    sin_idx = qq[SinIdxW] ? (SinIdxW + 1)'(SINE_TABLE_DEPTH) - {1'b0, qq[SinIdxW-1:0]}
                          : {1'b0, qq[SinIdxW-1:0]};
    sin_mag = SinTab[sin_idx];
    sine_w  = (qq[SinIdxW+1] ^ item_q.measured_angle[15]) ? 18'sd0 - signed'({1'b0, sin_mag})
                                                          : signed'({1'b0, sin_mag});
  end

  // per-step results
  logic signed [63:0] inner_w;
  logic signed [63:0] lead_s_w;
  logic signed [63:0] lead_y_w;
  logic signed [31:0] lead_y_sat;
  logic [15:0]        thrust_w;

  always_comb begin
    inner_w  = (mul_p >>> (ANGLE_FRAC_BITS + 8)) - 64'(item_q.measured_rate);
    lead_s_w = (acc_q + mul_p) >>> (ANGLE_FRAC_BITS - 8);
    lead_y_w = (acc_q - mul_p) >>> 16;
    if (lead_y_w > 64'sh7fffffff) begin
      lead_y_sat = 32'sh7fffffff;
    end else if (lead_y_w < -64'sh80000000) begin
      lead_y_sat = 32'sh80000000;
    end else begin
      lead_y_sat = lead_y_w[31:0];
    end
    if (total_q < 48'sd0) begin
      thrust_w = '0;
    end else if (total_q > signed'({32'd0, thrust_cap_q})) begin
      thrust_w = thrust_cap_q;
    end else begin
      thrust_w = total_q[15:0];
    end
  end

  // configuration writes, taken at any time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ff_gain_q    <= '0;
      lead_b0_q    <= '0;
      lead_b1_q    <= '0;
      lead_a1_q    <= '0;
      angle_gain_q <= '0;
      rate_gain_q  <= '0;
      thrust_cap_q <= 16'hffff;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegFfGain:    ff_gain_q    <= cfg_data_i;
        RegLeadB0:    lead_b0_q    <= cfg_data_i;
        RegLeadB1:    lead_b1_q    <= cfg_data_i;
        RegLeadA1:    lead_a1_q    <= cfg_data_i;
        RegAngleGain: angle_gain_q <= cfg_data_i;
        RegRateGain:  rate_gain_q  <= cfg_data_i;
        RegMaxThrust: thrust_cap_q <= cfg_data_i[15:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // sequencer: one multiply per state between idle and done, operands for the next one loaded on done
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      item_q      <= '0;
      err_q       <= '0;
      total_q     <= '0;
      acc_q       <= '0;
      inv_q       <= 1'b0;
      prev_err_q  <= '0;
      prev_y_q    <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      mul_go_q    <= 1'b0;
      mul_a_q     <= '0;
      mul_b_q     <= '0;
    end else begin
      mul_go_q <= mul_go_d;
      // drop a delivered result unless a new one replaces it this cycle
      if (out_valid_q && !out_stall_i && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            item_q <= in_data_i;
            err_q  <= err_in;
            if (op_ok) begin
              inv_q    <= 1'b0;
              mul_a_q  <= 64'(mag_in);
              mul_b_q  <= TwoOverPiQ30;
              state_q  <= ST_SIN;
            end else begin
              // pid and the unused code: flag it, thrust zero
              inv_q   <= 1'b1;
              total_q <= '0;
              state_q <= ST_DONE;
            end
          end
        end
        ST_SIN: begin
          if (mul_done) begin
            mul_a_q  <= 64'(ff_gain_q);
            mul_b_q  <= 32'(sine_w);
            state_q  <= ST_FF;
          end
        end
        ST_FF: begin
          if (mul_done) begin
            total_q  <= 48'(mul_p >>> 24);
            mul_b_q  <= 32'(err_q);
            if (item_q.op == OpCascade) begin
              mul_a_q <= 64'(angle_gain_q);
              state_q <= ST_CAS_ERR;
            end else begin
              mul_a_q <= 64'(lead_b0_q);
              state_q <= ST_LEAD_B0;
            end
          end
        end
        ST_CAS_ERR: begin
          if (mul_done) begin
            mul_a_q  <= 64'(rate_gain_q);
            mul_b_q  <= inner_w[31:0];
            state_q  <= ST_CAS_RATE;
          end
        end
        ST_CAS_RATE: begin
          if (mul_done) begin
            total_q <= total_q + 48'(mul_p >>> 16);
            state_q <= ST_DONE;
          end
        end
        ST_LEAD_B0: begin
          if (mul_done) begin
            acc_q    <= mul_p;
            mul_a_q  <= 64'(lead_b1_q);
            mul_b_q  <= 32'(prev_err_q);
            state_q  <= ST_LEAD_B1;
          end
        end
        ST_LEAD_B1: begin
          if (mul_done) begin
            acc_q    <= lead_s_w;
            mul_a_q  <= 64'(lead_a1_q);
            mul_b_q  <= prev_y_q;
            state_q  <= ST_LEAD_A1;
          end
        end
        ST_LEAD_A1: begin
          if (mul_done) begin
            total_q    <= total_q + 48'(lead_y_sat);
            prev_err_q <= err_q;
            prev_y_q   <= lead_y_sat;
            state_q    <= ST_DONE;
          end
        end
        ST_DONE: begin
          // hold until the output register is free
          if (!out_valid_q || !out_stall_i) begin
            out_q.thrust  <= inv_q ? 16'd0 : thrust_w;
            out_q.invalid <= inv_q;
            out_valid_q   <= 1'b1;
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

endmodule

/* rtl/aatc_chk.sv */
// Port-level checker for the arm angle thrust controller, bound to the top level.
module aatc_chk import aatc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input in_item_t    in_data_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input out_item_t   out_data_o,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic [2:0]  cfg_index_i,
  input logic [31:0] cfg_data_i
);

  // a transaction keeps the input side busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken back to back");

  // no result appears the cycle after a transaction
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o |=> !out_valid_o)
    else $error("result too early");

  // invalid results carry zero thrust
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.invalid |-> out_data_o.thrust == 16'd0)
    else $error("invalid result with thrust");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

endmodule

bind arm_angle_thrust_controller aatc_chk u_aatc_chk (.*);

/* tb/sv/arm_angle_thrust_controller_test.sv */
// Self-checking testbench for the arm angle thrust controller.
module arm_angle_thrust_controller_test;
  import aatc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ItemsPerPhase = 142;
  localparam int NumPhases     = 8;
  localparam int SettleCycles  = 200;  // outlasts the slowest (lead) item
  localparam int HoldCycles    = 600;
  localparam logic [2:0] RegUnused = 3'd7;

  // Idle profiles, cycled through the phases.
  typedef enum int {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_e;

  // One row of the directed table; the expected result is typed in where known.
  typedef struct {
    in_item_t  item;
    bit        has_exp;
    out_item_t exp;
  } directed_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_item_t   out_data_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  arm_angle_thrust_controller dut (.*);

  // Controller copy: configuration and lead filter state.
  logic signed [31:0] ff_gain_q, lead_b0_q, lead_b1_q, lead_a1_q, angle_gain_q, rate_gain_q;
  logic [15:0]        thrust_cap_q;
  logic signed [15:0] lead_err_q;
  logic signed [31:0] lead_out_q;
  longint unsigned    quarter_sine [0:SINE_TABLE_DEPTH];

  out_item_t  thrust_expected_q[$];
  idle_mode_e idle_mode;
  int         hold_left;
  int         mismatches;
  int         results_seen;
  int         items_sent;
  int         cfg_writes;

  // Build the quarter-wave sine: Taylor series in Q30, rounded to Q16.
  function automatic void build_quarter_sine();
    longint unsigned x, x2, term, e;
    longint          acc;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x    = (longint'(k) * HalfPiQ30 + SINE_TABLE_DEPTH / 2) / SINE_TABLE_DEPTH;
      x2   = (x * x + (64'd1 << 29)) >> 30;
      term = x;
      acc  = longint'(x);
      for (int n = 1; n <= 7; n++) begin
        term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
        acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      e = (longint'(acc) + (64'd1 << 13)) >> 14;
      quarter_sine[k] = (e > 65536) ? 65536 : e;
    end
  endfunction

  // Signed sine in Q16 of an angle in angle format, by table lookup.
  function automatic longint sine_of(longint a);
    longint unsigned mag, idx, wrapped, quad, rem;
    longint          v;
    mag     = (a < 0) ? longint'(-a) : longint'(a);
    idx     = (mag * SINE_TABLE_DEPTH * longint'(TwoOverPiQ30)
               + (64'd1 << (ANGLE_FRAC_BITS + 29))) >> (ANGLE_FRAC_BITS + 30);
    wrapped = idx % (4 * SINE_TABLE_DEPTH);
    quad    = wrapped / SINE_TABLE_DEPTH;
    rem     = wrapped % SINE_TABLE_DEPTH;
    v = longint'(quad[0] ? quarter_sine[SINE_TABLE_DEPTH - rem] : quarter_sine[rem]);
    if (quad >= 2) v = -v;
    return (a < 0) ? -v : v;
  endfunction

  // Work out the thrust command for one sample and advance the lead state.
  function automatic out_item_t predict_thrust(in_item_t it);
    out_item_t res;
    longint    err, total, inner, s, y;
    res = '0;
    if (it.op != OpCascade && it.op != OpLead) begin
      res.invalid = 1'b1;
      return res;
    end
    err = longint'(it.target_angle) - longint'(it.measured_angle);
    if (err > 32767) err = 32767;
    if (err < -32768) err = -32768;
    total = (longint'(ff_gain_q) * sine_of(longint'(it.measured_angle))) >>> 24;
    if (it.op == OpCascade) begin
      inner = ((longint'(angle_gain_q) * err) >>> (ANGLE_FRAC_BITS + 8))
              - longint'(it.measured_rate);
      total += (longint'(rate_gain_q) * inner) >>> 16;
    end else begin
      s = (longint'(lead_b0_q) * err + longint'(lead_b1_q) * longint'(lead_err_q))
          >>> (ANGLE_FRAC_BITS - 8);
      y = (s - longint'(lead_a1_q) * longint'(lead_out_q)) >>> 16;
      if (y > 64'sh7fffffff) y = 64'sh7fffffff;
      if (y < -64'sh80000000) y = -64'sh80000000;
      lead_err_q = 16'(err);
      lead_out_q = 32'(y);
      total += y;
    end
    if (total > longint'(thrust_cap_q)) total = longint'(thrust_cap_q);
    if (total < 0) total = 0;
    res.thrust = 16'(total);
    return res;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Generous watchdog, well above the slowest legal run.
  initial begin
    #12ms;
    $display("TEST FAILED");
    $finish;
  end

  // Receiver: check each transaction against the oldest expectation, then pick
  // the next stall. A hold request keeps the block stalled for a long stretch.
  initial begin
    out_item_t exp;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (thrust_expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result thrust=%0d invalid=%0b",
                                         out_data_o.thrust, out_data_o.invalid);
        end else begin
          exp = thrust_expected_q.pop_front();
          if (out_data_o.thrust !== exp.thrust || out_data_o.invalid !== exp.invalid) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: thrust exp %0d got %0d, invalid exp %0b got %0b",
                       exp.thrust, out_data_o.thrust, exp.invalid, out_data_o.invalid);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (idle_mode == IdleReceiver) begin
        out_stall_i <= ($urandom_range(99) < 55);
      end else if (idle_mode == IdleBoth) begin
        out_stall_i <= ($urandom_range(99) < 37);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Offer one sample and hold it until accepted; record its expected result.
  task automatic send_sample(in_item_t it, bit has_exp, out_item_t exp_typed);
    out_item_t predicted;
    int        gap;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    predicted = predict_thrust(it);
    thrust_expected_q.push_back(has_exp ? exp_typed : predicted);
    items_sent++;
    gap = 0;
    if (idle_mode == IdleSender && $urandom_range(99) < 55) gap = $urandom_range(1, 6);
    if (idle_mode == IdleBoth && $urandom_range(99) < 37) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Write one register while the block is idle, and mirror it. Valid stays up
  // for a following write; the caller drops it after the last one.
  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_writes++;
    case (idx)
      RegFfGain:    ff_gain_q    = value;
      RegLeadB0:    lead_b0_q    = value;
      RegLeadB1:    lead_b1_q    = value;
      RegLeadA1:    lead_a1_q    = value;
      RegAngleGain: angle_gain_q = value;
      RegRateGain:  rate_gain_q  = value;
      RegMaxThrust: thrust_cap_q = value[15:0];
      default: ;
    endcase
  endtask

  // Wait until every expected result is in, then let the pipeline settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (thrust_expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] rand_field();
    return ($urandom_range(1) == 1) ? 16'($urandom) : 16'($urandom_range(16383) - 8192);
  endfunction

  function automatic logic signed [31:0] small_gain();
    return 32'($urandom_range(1 << 19) - (1 << 18));
  endfunction

  directed_row_t directed [$];

  initial begin
    directed_row_t r;
    in_item_t      it;
    logic [31:0]   g [7];
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = RegFfGain;
    cfg_data_i  = '0;
    idle_mode   = IdleNone;
    hold_left   = 0;
    mismatches  = 0;
    results_seen = 0;
    items_sent  = 0;
    cfg_writes  = 0;
    build_quarter_sine();
    ff_gain_q = '0; lead_b0_q = '0; lead_b1_q = '0; lead_a1_q = '0;
    angle_gain_q = '0; rate_gain_q = '0; thrust_cap_q = 16'hffff;
    lead_err_q = '0; lead_out_q = '0;

    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset gains give zero thrust; pid and the unused mode flag invalid.
    r.has_exp = 1'b1;
    r.item = '{OpPid, 16'sh7fff, 16'sh8000, 16'sh7fff};  r.exp = '{16'd0, 1'b1};
    directed.push_back(r);
    r.item = '{2'd3, 16'sh8000, 16'sh7fff, 16'sh8000};   r.exp = '{16'd0, 1'b1};
    directed.push_back(r);
    r.item = '{OpCascade, 16'sh7fff, 16'sh8000, 16'sh8000}; r.exp = '{16'd0, 1'b0};
    directed.push_back(r);
    r.item = '{OpCascade, 16'sh8000, 16'sh7fff, 16'sh7fff}; r.exp = '{16'd0, 1'b0};
    directed.push_back(r);
    r.item = '{OpLead, 16'sh7fff, 16'sh8000, 16'sh0000};    r.exp = '{16'd0, 1'b0};
    directed.push_back(r);
    r.item = '{OpLead, 16'sh8000, 16'sh7fff, 16'shffff};    r.exp = '{16'd0, 1'b0};
    directed.push_back(r);
    r.item = '{OpPid, 16'sh0000, 16'sh0000, 16'sh0000};     r.exp = '{16'd0, 1'b1};
    directed.push_back(r);
    r.item = '{OpCascade, 16'sh0000, 16'sh0000, 16'sh0000}; r.exp = '{16'd0, 1'b0};
    directed.push_back(r);
    foreach (directed[i]) send_sample(directed[i].item, directed[i].has_exp, directed[i].exp);
    drain();

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0, 3: g = '{32'sd196608, 32'sd163840, -32'sd150000, -32'sd32768,
                    32'sd262144, 32'sd65536, (ph == 3) ? 32'd0 : 32'h3000};
        1: g = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                 32'h7fffffff, 32'h7fffffff, 32'h0000ffff};
        2: g = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                 32'h80000000, 32'h80000000, 32'h0000ffff};
        5: g = '{small_gain(), small_gain(), small_gain(), small_gain(),
                 small_gain(), small_gain(), 32'($urandom)};
        default: g = '{$urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom};
      endcase
      for (int k = 0; k < 7; k++) write_reg(3'(k), g[k]);
      write_reg(RegUnused, $urandom);  // out of range, must be dropped
      cfg_valid_i <= 1'b0;
      idle_mode = idle_mode_e'(ph % 4);
      // Long receiver hold-off with the sender still pushing: fill the block.
      if (ph == 0) hold_left = HoldCycles;
      for (int n = 0; n < ItemsPerPhase; n++) begin
        it.op = ($urandom_range(99) < 90) ? 2'($urandom_range(OpCascade, OpLead))
                                          : 2'($urandom);
        it.target_angle   = rand_field();
        it.measured_angle = rand_field();
        it.measured_rate  = rand_field();
        send_sample(it, 1'b0, '0);
      end
      drain();
    end

    $display("covered %0d samples over %0d gain settings, %0d register writes, %0d results",
             items_sent, NumPhases + 1, cfg_writes, results_seen);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
